// File: design/twil_pkg.sv
// Shared constants, types and result codes for the trie word insert and lookup block.
package twil_pkg;

    // Node pool and alphabet
    localparam int NODE_COUNT    = 4096;
    localparam int ALPHABET_SIZE = 26;

    // Derived widths
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int CNT_W       = $clog2(NODE_COUNT + 1);
    localparam int SLOT_W      = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

    // Word widths on the stream ports
    localparam int LETTER_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = 8;

    // Letter range
    localparam logic [LETTER_W-1:0] LETTER_LOW  = 8'h61;
    localparam logic [LETTER_W-1:0] LETTER_HIGH = 8'h7A;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_FIND   = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_LETTER = 2'd2;

    // Result handed from the walker to the output stage
    typedef struct packed {
        logic                valid;
        logic                found;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// File: design/twil_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module twil_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/twil_walk.sv
// Trie walker: clearing sweep, child table and word-end RAMs, per-letter read-modify-write.
module twil_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [twil_pkg::LETTER_W-1:0] i_letter,
    input  logic                          i_last,
    output twil_pkg::t_result             o_res,
    input  logic                          i_res_ready
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MARK,
        ST_RESP
    } t_state;

    t_state                              r_state, n_state;
    logic [twil_pkg::CHILD_AW-1:0]       r_clr_addr, n_clr_addr;
    logic [twil_pkg::NODE_W-1:0]         r_cursor, n_cursor;
    logic [twil_pkg::CNT_W-1:0]          r_used, n_used;
    logic                                r_failed, n_failed;
    logic [twil_pkg::STATUS_W-1:0]       r_fail_kind, n_fail_kind;
    logic                                r_action, n_action;
    logic                                r_last, n_last;
    logic [twil_pkg::CHILD_AW-1:0]       r_addr, n_addr;
    logic                                r_found, n_found;
    logic [twil_pkg::STATUS_W-1:0]       r_status, n_status;

    // RAM side
    logic                                child_we;
    logic [twil_pkg::CHILD_AW-1:0]       child_waddr;
    logic [twil_pkg::NODE_W-1:0]         child_wdata;
    logic [twil_pkg::CHILD_AW-1:0]       child_raddr;
    logic [twil_pkg::NODE_W-1:0]         child_rdata;
    logic                                mark_we;
    logic [twil_pkg::NODE_W-1:0]         mark_waddr;
    logic                                mark_wdata;
    logic                                mark_rdata;

    // letter decode
    logic [twil_pkg::LETTER_W-1:0]       slot_full;
    logic [twil_pkg::SLOT_W-1:0]         slot;
    logic                                letter_ok;
    logic                                accept;
    logic [twil_pkg::NODE_W-1:0]         new_node;

    assign slot_full = i_letter - twil_pkg::LETTER_LOW;
    assign slot      = slot_full[twil_pkg::SLOT_W-1:0];
    assign letter_ok = (i_letter >= twil_pkg::LETTER_LOW)
                    && (i_letter <= twil_pkg::LETTER_HIGH)
                    && (slot_full < twil_pkg::LETTER_W'(twil_pkg::ALPHABET_SIZE));
    assign o_ready   = (r_state == ST_IDLE);
    assign accept    = i_valid && o_ready;
    assign new_node  = r_used[twil_pkg::NODE_W-1:0];

    // slot address of the current node, read on the accept edge
    assign child_raddr = twil_pkg::CHILD_AW'(r_cursor)
                       * twil_pkg::CHILD_AW'(twil_pkg::ALPHABET_SIZE)
                       + twil_pkg::CHILD_AW'(slot);

    twil_ram #(
        .WIDTH (twil_pkg::NODE_W),
        .DEPTH (twil_pkg::CHILD_DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_raddr (child_raddr),
        .o_rdata (child_rdata)
    );

    // word-end read address is the child just fetched
    twil_ram #(
        .WIDTH (1),
        .DEPTH (twil_pkg::NODE_COUNT)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (child_rdata),
        .o_rdata (mark_rdata)
    );

    assign o_res.valid  = (r_state == ST_RESP);
    assign o_res.found  = r_found;
    assign o_res.status = r_status;

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cursor    = r_cursor;
        n_used      = r_used;
        n_failed    = r_failed;
        n_fail_kind = r_fail_kind;
        n_action    = r_action;
        n_last      = r_last;
        n_addr      = r_addr;
        n_found     = r_found;
        n_status    = r_status;
        child_we    = 1'b0;
        child_waddr = r_addr;
        child_wdata = new_node;
        mark_we     = 1'b0;
        mark_waddr  = child_rdata;
        mark_wdata  = 1'b1;

        unique case (r_state)
            ST_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = r_clr_addr;
                child_wdata = '0;
                mark_we     = (r_clr_addr < twil_pkg::CHILD_AW'(twil_pkg::NODE_COUNT));
                mark_waddr  = r_clr_addr[twil_pkg::NODE_W-1:0];
                mark_wdata  = 1'b0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == twil_pkg::CHILD_AW'(twil_pkg::CHILD_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_last   = i_last;
                    n_found  = 1'b0;
                    if (r_failed) begin
                        // held error: letter ignored
                        n_status = r_fail_kind;
                        if (i_last) begin
                            n_state = ST_RESP;
                        end
                    end else if (!letter_ok) begin
                        n_failed    = 1'b1;
                        n_fail_kind = twil_pkg::STATUS_BAD_LETTER;
                        n_status    = twil_pkg::STATUS_BAD_LETTER;
                        if (i_last) begin
                            n_state = ST_RESP;
                        end
                    end else begin
                        n_addr  = child_raddr;
                        n_state = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                n_status = twil_pkg::STATUS_OK;
                n_found  = 1'b0;
                n_state  = r_last ? ST_RESP : ST_IDLE;
                if (r_action == twil_pkg::ACT_INSERT) begin
                    if (child_rdata == '0) begin
                        if (r_used >= twil_pkg::CNT_W'(twil_pkg::NODE_COUNT)) begin
                            n_failed    = 1'b1;
                            n_fail_kind = twil_pkg::STATUS_FULL;
                            n_status    = twil_pkg::STATUS_FULL;
                        end else begin
                            // allocate the next free node
                            child_we   = 1'b1;
                            n_used     = r_used + 1'b1;
                            n_cursor   = new_node;
                            mark_we    = r_last;
                            mark_waddr = new_node;
                        end
                    end else begin
                        n_cursor   = child_rdata;
                        mark_we    = r_last;
                        mark_waddr = child_rdata;
                    end
                end else begin
                    if (child_rdata == '0) begin
                        n_failed    = 1'b1;
                        n_fail_kind = twil_pkg::STATUS_OK;
                    end else begin
                        n_cursor = child_rdata;
                        // word-end bit comes back next cycle
                        if (r_last) begin
                            n_state = ST_MARK;
                        end
                    end
                end
            end

            ST_MARK: begin
                n_found = mark_rdata;
                n_state = ST_RESP;
            end

            ST_RESP: begin
                if (i_res_ready) begin
                    n_cursor    = '0;
                    n_failed    = 1'b0;
                    n_fail_kind = twil_pkg::STATUS_OK;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_cursor    <= '0;
            r_used      <= twil_pkg::CNT_W'(1);
            r_failed    <= 1'b0;
            r_fail_kind <= twil_pkg::STATUS_OK;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cursor    <= n_cursor;
            r_used      <= n_used;
            r_failed    <= n_failed;
            r_fail_kind <= n_fail_kind;
        end
        r_action <= n_action;
        r_last   <= n_last;
        r_addr   <= n_addr;
        r_found  <= n_found;
        r_status <= n_status;
    end

endmodule

// File: design/trie_word_insert_lookup_top.sv
// Top level of the trie word insert and lookup block: stream ports and output register.
//
//  channel  | dir | tdata                          | tuser     | tlast
//  ---------+-----+--------------------------------+-----------+-------------
//  s (in)   | in  | [7:0] letter                   | [0] action| last letter
//  m (out)  | out | [0] found, [2:1] status, zeros | -         | -
//
// A valid letter goes through a child slot read, then a write-back; a find on
// the last letter adds one more read for the word-end bit. A bad letter or a
// letter after a held error is handled in the idle state without a RAM read.
// A result then passes into the output register. After reset a clearing sweep
// runs over all 106496 child table slots before the first word is taken. A
// stalled result holds the walker only when a new result is ready behind it.
module trie_word_insert_lookup_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [twil_pkg::LETTER_W-1:0]   i_s_tdata,  // [7:0] letter
    input  logic                            i_s_tuser,  // [0] action
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [twil_pkg::OUT_DATA_W-1:0] o_m_tdata   // [0] found, [2:1] status
);

    twil_pkg::t_result             res;
    logic                          res_ready;
    logic                          r_out_valid;
    logic                          r_out_found;
    logic [twil_pkg::STATUS_W-1:0] r_out_status;

    assign res_ready = !r_out_valid || i_m_tready;

    twil_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_action    (i_s_tuser),
        .i_letter    (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
        if (res_ready && res.valid) begin
            r_out_found  <= res.found;
            r_out_status <= res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(twil_pkg::OUT_DATA_W - twil_pkg::STATUS_W - 1)'(0),
                         r_out_status, r_out_found};

endmodule
